// ===== src/wtcp_pkg.sv =====
`default_nettype none
package wtcp_pkg;

  // Default geometry
  localparam int CELLS_DEF    = 1024;
  localparam int CHANNELS_DEF = 4;

  // Field widths
  localparam int CH_W     = 2;
  localparam int IDX_W    = 10;
  localparam int WIDTH_W  = 24;
  localparam int SAMPLE_W = 16;
  localparam int TRIG_W   = 10;
  localparam int RANGE_W  = 10;
  localparam int TIME_W   = 34;
  localparam int MV_W     = 28;
  localparam int PEAK_W   = 27;

  // Packed channel widths
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 128;

  // Input tdata offsets
  localparam int CH_LSB     = 0;
  localparam int IDX_LSB    = CH_LSB + CH_W;
  localparam int WIDTH_LSB  = IDX_LSB + IDX_W;
  localparam int SAMPLE_LSB = WIDTH_LSB + WIDTH_W;
  localparam int TRIG_LSB   = SAMPLE_LSB + SAMPLE_W;
  localparam int RANGE_LSB  = TRIG_LSB + TRIG_W;

  // Item kinds carried on in_tuser
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Double-mode decision limits on the last calibration entry
  localparam logic [WIDTH_W-1:0] WIDE_LIMIT   = 24'd655360;
  localparam logic [WIDTH_W-1:0] NARROW_LIMIT = 24'd655;

  localparam logic [SAMPLE_W-1:0] MV_SCALE   = 16'd1000;
  localparam int                  RANGE_BIAS = 500;

  // Sample transaction handed from the front end to the accumulator
  typedef struct packed {
    logic            width_ok;
    logic [MV_W-1:0] mv;
    logic            last;
  } wtcp_item_t;

endpackage
`default_nettype wire

// ===== src/wtcp_width_mem.sv =====
`default_nettype none
module wtcp_width_mem
  import wtcp_pkg::*;
#(
  parameter int DEPTH = CELLS_DEF * CHANNELS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [AW-1:0]      wr_addr,
  input  wire logic [WIDTH_W-1:0] wr_data,
  input  wire logic               rd_en,
  input  wire logic [AW-1:0]      rd_addr,
  output logic      [WIDTH_W-1:0] rd_data
);

  logic [WIDTH_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next sample is taken
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/wtcp_front.sv =====
`default_nettype none
module wtcp_front
  import wtcp_pkg::*;
#(
  parameter int CELLS    = CELLS_DEF,
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int AW       = $clog2(CELLS * CHANNELS)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic                  mode,
  input  wire logic [IN_TDATA_W-1:0] data,
  input  wire logic                  last,
  output logic                       wr_en,
  output logic      [AW-1:0]         wr_addr,
  output logic      [WIDTH_W-1:0]    wr_data,
  output logic                       rd_en,
  output logic      [AW-1:0]         rd_addr,
  output wtcp_item_t                 item
);

  localparam int CW      = $clog2(CELLS);
  localparam int RCP_SH  = 24;
  localparam int RCP     = ((1 << RCP_SH) + CELLS - 1) / CELLS;
  localparam int PROD_W  = TRIG_W + RCP_SH + 1;

  logic [CH_W-1:0]     ch;
  logic [IDX_W-1:0]    idx;
  logic [WIDTH_W-1:0]  wval;
  logic [SAMPLE_W-1:0] smp;
  logic [TRIG_W-1:0]   trig;
  logic [RANGE_W-1:0]  rng;

  logic                ch_ok;
  logic                idx_ok;
  logic                dbl;
  logic [PROD_W-1:0]   prod;
  logic [31:0]         trig_rem;
  logic [CW-1:0]       trig_mod;
  logic [CW:0]         cell_sum;
  logic [CW-1:0]       cell_wrap;
  logic [CW-1:0]       rd_cell;
  logic [11:0]         rng_off;
  logic [MV_W-1:0]     smp_scaled;

  logic [CW-1:0]       pos_r;
  logic [CW-1:0]       pos_nxt;
  logic [CHANNELS-1:0] dbl_r;
  logic [CHANNELS-1:0] dbl_nxt;

  assign ch   = data[CH_LSB +: CH_W];
  assign idx  = data[IDX_LSB +: IDX_W];
  assign wval = data[WIDTH_LSB +: WIDTH_W];
  assign smp  = data[SAMPLE_LSB +: SAMPLE_W];
  assign trig = data[TRIG_LSB +: TRIG_W];
  assign rng  = data[RANGE_LSB +: RANGE_W];

  assign ch_ok  = 32'(ch) < 32'(CHANNELS);
  assign idx_ok = 32'(idx) < 32'(CELLS);

  // Trigger cell modulo CELLS by reciprocal multiply; exact for 10-bit cells
  always_comb begin
    prod     = PROD_W'(trig) * PROD_W'(RCP);
    trig_rem = 32'(trig) - 32'(prod[PROD_W-1:RCP_SH]) * 32'(CELLS);
    trig_mod = trig_rem[CW-1:0];
  end

  always_comb begin
    cell_sum = {1'b0, pos_r} + {1'b0, trig_mod};
    if (cell_sum >= (CW+1)'(CELLS)) begin
      cell_wrap = CW'(cell_sum - (CW+1)'(CELLS));
    end else begin
      cell_wrap = cell_sum[CW-1:0];
    end
    dbl = ch_ok && dbl_r[ch];
    // Fold the upper half onto the lower half in double mode
    if (dbl && (cell_wrap >= CW'(CELLS / 2))) begin
      rd_cell = cell_wrap - CW'(CELLS / 2);
    end else begin
      rd_cell = cell_wrap;
    end
  end

  assign rd_en   = accept && (mode == MODE_SAMPLE);
  assign rd_addr = AW'(32'(ch) * 32'(CELLS) + 32'(rd_cell));

  assign wr_en   = accept && (mode == MODE_LOAD) && ch_ok && idx_ok;
  assign wr_addr = AW'(32'(ch) * 32'(CELLS) + 32'(idx));
  assign wr_data = wval;

  // Millivolts in 2^-16 mV: sample*1000 + (range-500)*65536
  always_comb begin
    rng_off    = {{2{rng[RANGE_W-1]}}, rng} - 12'(RANGE_BIAS);
    smp_scaled = MV_W'(smp) * MV_W'(MV_SCALE);
    item.mv       = smp_scaled + {rng_off, 16'b0};
    item.width_ok = ch_ok;
    item.last     = last;
  end

  always_comb begin
    pos_nxt = pos_r;
    if (rd_en) begin
      if (last || (pos_r == CW'(CELLS - 1))) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + CW'(1);
      end
    end
  end

  always_comb begin
    dbl_nxt = dbl_r;
    if (wr_en && (32'(idx) == 32'(CELLS - 1))) begin
      dbl_nxt[ch] = (wval > WIDE_LIMIT) || (wval <= NARROW_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      dbl_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      dbl_r <= dbl_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/wtcp_accum.sv =====
`default_nettype none
module wtcp_accum
  import wtcp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               item_valid,
  input  wire wtcp_item_t         item,
  output logic                    item_ready,
  input  wire logic [WIDTH_W-1:0] width,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [TIME_W-1:0]  cell_time,
  output logic      [MV_W-1:0]    millivolts,
  output logic      [PEAK_W-1:0]  peak_magnitude,
  output logic      [TIME_W-1:0]  peak_time,
  output logic                    waveform_end
);

  logic              s2_valid_r;
  logic              s2_valid_nxt;
  wtcp_item_t        s2_item_r;
  logic              s2_adv;

  logic [TIME_W-1:0] acc_r;
  logic [TIME_W-1:0] acc_nxt;
  logic [PEAK_W-1:0] peak_r;
  logic [PEAK_W-1:0] peak_nxt;
  logic [TIME_W-1:0] ptime_r;
  logic [TIME_W-1:0] ptime_nxt;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [TIME_W-1:0] ct_r;
  logic [MV_W-1:0]   mv_r;
  logic [PEAK_W-1:0] pk_r;
  logic [TIME_W-1:0] pt_r;
  logic              end_r;

  logic [MV_W-1:0]   mv_abs;
  logic [PEAK_W-1:0] mag;

  assign s2_adv     = s2_valid_r && (!out_valid_r || out_ready);
  assign item_ready = !s2_valid_r || s2_adv;

  always_comb begin
    mv_abs = s2_item_r.mv[MV_W-1] ? (~s2_item_r.mv + MV_W'(1)) : s2_item_r.mv;
    mag    = mv_abs[PEAK_W-1:0];
  end

  always_comb begin
    acc_nxt   = acc_r;
    peak_nxt  = peak_r;
    ptime_nxt = ptime_r;
    if (s2_adv) begin
      if (s2_item_r.last) begin
        acc_nxt   = '0;
        peak_nxt  = '0;
        ptime_nxt = '0;
      end else begin
        // Advance time by this cell's width; unknown channels add nothing
        if (s2_item_r.width_ok) begin
          acc_nxt = acc_r + TIME_W'(width);
        end
        if (mag > peak_r) begin
          peak_nxt  = mag;
          ptime_nxt = acc_r;
        end
      end
    end
  end

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (item_ready) begin
      s2_valid_nxt = item_valid;
    end
    out_valid_nxt = out_valid_r;
    if (s2_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      peak_r      <= '0;
      ptime_r     <= '0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      peak_r      <= peak_nxt;
      ptime_r     <= ptime_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s2_item_r <= item;
    end
    if (s2_adv) begin
      ct_r  <= acc_r;
      mv_r  <= s2_item_r.mv;
      end_r <= s2_item_r.last;
      if (mag > peak_r) begin
        pk_r <= mag;
        pt_r <= acc_r;
      end else begin
        pk_r <= peak_r;
        pt_r <= ptime_r;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign cell_time      = ct_r;
  assign millivolts     = mv_r;
  assign peak_magnitude = pk_r;
  assign peak_time      = pt_r;
  assign waveform_end   = end_r;

endmodule
`default_nettype wire

// ===== src/waveform_time_calibration_peak.sv =====
// Throughput: one transaction per cycle, loads and samples alike, while back-pressure
// does not hold in_tready low; the width table read overlaps the accumulate and peak
// stage of the previous sample.
// Reset (synchronous, rst_n low): pipeline, cell position, time, peak and the
// double-mode flags clear at once; the width table is not initialised.
`default_nettype none
module waveform_time_calibration_peak
  import wtcp_pkg::*;
#(
  parameter int CELLS    = CELLS_DEF,
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // channel, cell_index, width_value, sample, trigger position, range_mv
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // mode
  input  wire logic                   in_tuser,
  input  wire logic                   in_tlast,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // cell_time, millivolts, peak_magnitude, peak_time, zero pad
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  output logic                        out_tlast
);

  localparam int DEPTH = CELLS * CHANNELS;
  localparam int AW    = $clog2(DEPTH);

  logic               accept;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [WIDTH_W-1:0] wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [WIDTH_W-1:0] rd_data;
  wtcp_item_t         item;

  logic [TIME_W-1:0]  cell_time;
  logic [MV_W-1:0]    millivolts;
  logic [PEAK_W-1:0]  peak_magnitude;
  logic [TIME_W-1:0]  peak_time;

  assign accept = in_tvalid && in_tready;

  wtcp_front #(
    .CELLS    (CELLS),
    .CHANNELS (CHANNELS),
    .AW       (AW)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .mode    (in_tuser),
    .data    (in_tdata),
    .last    (in_tlast),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .item    (item)
  );

  wtcp_width_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wtcp_accum u_accum (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (rd_en),
    .item           (item),
    .item_ready     (in_tready),
    .width          (rd_data),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .cell_time      (cell_time),
    .millivolts     (millivolts),
    .peak_magnitude (peak_magnitude),
    .peak_time      (peak_time),
    .waveform_end   (out_tlast)
  );

  assign out_tdata = {
    (OUT_TDATA_W - TIME_W - MV_W - PEAK_W - TIME_W)'(0),
    peak_time, peak_magnitude, millivolts, cell_time
  };

endmodule
`default_nettype wire
